@@ sv/gas_pkg.sv @@
// ----------------------------------------------------------------------------
// gas_pkg: shared types and constants for the grid A* path search
// Field widths, status codes and cost widths used by the interfaces and the search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gas_pkg;

    localparam int CoordW = 3;
    localparam int GW     = 14;
    localparam int FW     = 16;
    localparam int OrdW   = 7;
    localparam int CostW  = 8;
    localparam int DimW   = 4;
    localparam int HeurScale = 10;

    localparam logic [1:0] STATUS_PATH    = 2'd0;
    localparam logic [1:0] STATUS_NO_PATH = 2'd1;
    localparam logic [1:0] STATUS_BAD_END = 2'd2;

    localparam logic       ACTION_LOAD  = 1'b0;
    localparam logic       ACTION_SOLVE = 1'b1;

    localparam logic [1:0] REG_STRAIGHT = 2'd0;
    localparam logic [1:0] REG_DIAGONAL = 2'd1;
    localparam logic [1:0] REG_ROWS     = 2'd2;
    localparam logic [1:0] REG_COLS     = 2'd3;

    typedef struct packed {
        logic                action;
        logic [CoordW-1:0]   pos_row;
        logic [CoordW-1:0]   pos_col;
        logic                blocked;
        logic [CoordW-1:0]   target_row;
        logic [CoordW-1:0]   target_col;
    } gas_in_t;

    typedef struct packed {
        logic [CoordW-1:0]   path_row;
        logic [CoordW-1:0]   path_col;
        logic [1:0]          status;
        logic                last;
    } gas_out_t;

    typedef struct packed {
        logic [1:0]          index;
        logic [CostW-1:0]    data;
    } gas_cfg_t;

endpackage

`default_nettype wire

@@ sv/gas_if.sv @@
// ----------------------------------------------------------------------------
// gas_if: valid/ready channel interfaces
// Item, result and configuration channels of the path search block.
// ----------------------------------------------------------------------------
`default_nettype none

interface gas_in_if import gas_pkg::*; ();
    logic    valid;
    logic    ready;
    gas_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gas_out_if import gas_pkg::*; ();
    logic     valid;
    logic     ready;
    gas_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gas_cfg_if import gas_pkg::*; ();
    logic     valid;
    logic     ready;
    gas_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/gas_ram.sv @@
// ----------------------------------------------------------------------------
// gas_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

@@ sv/grid_astar_path_search.sv @@
// ----------------------------------------------------------------------------
// grid_astar_path_search: eight-connected A* search over a small grid
// Loads blocked bits, solves start-to-target paths, emits path cells.
// ----------------------------------------------------------------------------
// A load transfer writes one cell's blocked bit. A solve transfer runs A* with
// one sequencer. Cells are addressed by row and column bit fields, so there
// are 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cell slots, 64 for an 8 by 8 grid.
// Every expansion scans all slots through one shared compare unit, with a
// read issue and then a compare on the registered data for each slot. It then
// fetches G of the expanded cell and reads and updates each of the nine
// neighbour positions in turn. The last expansion stops early once the target
// is found as a valid neighbour. The parent walk then follows the parent
// links from the target to the start into the path chain, and each path
// result goes through a chain read, a result load, valid raised and the
// transfer. A status result from the endpoint check is offered on the cycle
// after the check. The input is not ready during a solve. Open and closed
// marks live in flip-flops and are reset when a solve with valid, distinct
// endpoints starts; G, F, insertion order, parent and the path chain live in
// RAMs, of which only entries written in the solve are used. Configuration
// writes are always accepted and should only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_astar_path_search
    import gas_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input wire logic  clk,
    input wire logic  rst_n,
    gas_in_if.sink    item_in,
    gas_out_if.source result_out,
    gas_cfg_if.sink   cfg
);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int AW     = RW + CW;
    localparam int NCells = 2 ** AW;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_SCANW  = 4'd3;
    localparam logic [3:0] S_EXPAND = 4'd4;
    localparam logic [3:0] S_NREAD  = 4'd5;
    localparam logic [3:0] S_NUPD   = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_WALKW  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_GREAD  = 4'd11;
    localparam logic [3:0] S_EMITW  = 4'd12;

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic [CostW-1:0] straight_reg, diagonal_reg;
    logic [DimW-1:0]  rows_reg, cols_reg;

    logic [NCells-1:0] blocked_reg, open_reg, closed_reg;

    logic [CoordW-1:0] sr_reg, sc_reg, tr_reg, tc_reg;
    logic [OrdW-1:0]   order_reg;
    logic [AW:0]       idx_reg;           // scan index, wide enough for NCells
    logic              have_best_reg;
    logic [AW-1:0]     best_reg;
    logic [FW-1:0]     best_f_reg;
    logic [OrdW-1:0]   best_o_reg;
    logic [GW-1:0]     best_g_reg;
    logic [3:0]        nb_reg;            // neighbour index 0..8
    logic [GW-1:0]     ng_reg;
    logic [AW-1:0]     nk_reg;
    logic              nvalid_reg;

    // path chain: written target first, read back from the far end
    logic [AW:0]       clen_reg;
    logic [AW-1:0]     walk_reg;
    gas_out_t          res_reg;
    logic              res_valid_reg;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [GW-1:0] g_wdata, g_rdata;
    logic [FW-1:0] f_wdata, f_rdata;
    logic [OrdW-1:0] o_wdata, o_rdata;
    logic [AW-1:0] p_wdata, p_rdata;
    logic          o_we;
    logic          c_we;
    logic [AW-1:0] c_rdata;

    gas_ram #(.WIDTH(GW), .DEPTH(NCells)) u_g_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(g_wdata),
        .raddr(ram_raddr), .rdata(g_rdata));
    gas_ram #(.WIDTH(FW), .DEPTH(NCells)) u_f_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(f_wdata),
        .raddr(ram_raddr), .rdata(f_rdata));
    gas_ram #(.WIDTH(OrdW), .DEPTH(NCells)) u_o_ram (
        .clk(clk), .we(o_we), .waddr(ram_waddr), .wdata(o_wdata),
        .raddr(ram_raddr), .rdata(o_rdata));
    gas_ram #(.WIDTH(AW), .DEPTH(NCells)) u_p_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(p_wdata),
        .raddr(ram_raddr), .rdata(p_rdata));

    // clamped grid size
    logic [DimW-1:0] nr, nc;
    always_comb
    begin
        nr = (rows_reg == '0) ? DimW'(1) :
             (rows_reg > DimW'(MAX_ROWS)) ? DimW'(MAX_ROWS) : rows_reg;
        nc = (cols_reg == '0) ? DimW'(1) :
             (cols_reg > DimW'(MAX_COLS)) ? DimW'(MAX_COLS) : cols_reg;
    end

    // cell address: row bits above column bits
    function automatic logic [AW-1:0] cell_of(input logic [CoordW-1:0] r,
                                              input logic [CoordW-1:0] c);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    // Manhattan distance times ten, shared by start and neighbour paths
    function automatic logic [FW-1:0] heur(input logic [CoordW:0] r,
                                           input logic [CoordW:0] c,
                                           input logic [CoordW-1:0] tr,
                                           input logic [CoordW-1:0] tc);
        logic [CoordW:0]   dr, dc;
        logic [CoordW+1:0] s;
        dr = (r > {1'b0, tr}) ? r - {1'b0, tr} : {1'b0, tr} - r;
        dc = (c > {1'b0, tc}) ? c - {1'b0, tc} : {1'b0, tc} - c;
        s  = {1'b0, dr} + {1'b0, dc};
        return FW'(s) * FW'(HeurScale);
    endfunction

    // expanded cell coordinates and current neighbour
    logic [CoordW:0] br, bc, nbr, nbc;
    logic [1:0]      ddr, ddc;
    logic            nb_in;
    logic            nb_diag;
    always_comb
    begin
        br  = (CoordW+1)'(best_reg[AW-1:CW]);
        bc  = (CoordW+1)'(best_reg[CW-1:0]);
        ddr = (nb_reg >= 4'd6) ? 2'd2 : ((nb_reg >= 4'd3) ? 2'd1 : 2'd0);
        ddc = 2'(nb_reg - 4'({ddr, 1'b0}) - 4'(ddr));
        nbr = br + (CoordW+1)'(ddr) - (CoordW+1)'(1);
        nbc = bc + (CoordW+1)'(ddc) - (CoordW+1)'(1);
        nb_diag = (ddr != 2'd1) && (ddc != 2'd1);
        nb_in = (nb_reg != 4'd4)
                && !(br == '0 && ddr == 2'd0) && !(bc == '0 && ddc == 2'd0)
                && (nbr < (CoordW+1)'(nr)) && (nbc < (CoordW+1)'(nc));
    end

    logic [AW-1:0] nb_cell;
    assign nb_cell = cell_of(nbr[CoordW-1:0], nbc[CoordW-1:0]);

    logic [AW-1:0] s_cell, t_cell, scan_cell;
    assign s_cell    = cell_of(sr_reg, sc_reg);
    assign t_cell    = cell_of(tr_reg, tc_reg);
    assign scan_cell = idx_reg[AW-1:0];

    // endpoints inside the grid in use and clear; start equal to target
    logic ends_ok, same_end;
    assign ends_ok  = ({1'b0, sr_reg} < nr) && ({1'b0, sc_reg} < nc)
                      && ({1'b0, tr_reg} < nr) && ({1'b0, tc_reg} < nc)
                      && !blocked_reg[s_cell] && !blocked_reg[t_cell];
    assign same_end = (sr_reg == tr_reg) && (sc_reg == tc_reg);

    // shared compare: F then insertion order
    logic better;
    assign better = !have_best_reg || (f_rdata < best_f_reg)
                    || (f_rdata == best_f_reg && o_rdata < best_o_reg);

    logic [GW-1:0] ng_calc;
    assign ng_calc = best_g_reg + GW'(nb_diag ? diagonal_reg : straight_reg);

    logic in_fire, out_fire;
    assign in_fire  = item_in.valid && item_in.ready;
    assign out_fire = result_out.valid && result_out.ready;
    assign item_in.ready  = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign result_out.valid = res_valid_reg;
    assign result_out.data  = res_reg;

    logic [AW:0] emit_pos;
    assign emit_pos = clen_reg - (AW+1)'(1);

    // path chain store
    assign c_we = (state_reg == S_WALKW);
    gas_ram #(.WIDTH(AW), .DEPTH(NCells)) u_c_ram (
        .clk(clk), .we(c_we), .waddr(clen_reg[AW-1:0]), .wdata(walk_reg),
        .raddr(emit_pos[AW-1:0]), .rdata(c_rdata));

    // RAM control
    always_comb
    begin
        ram_we    = 1'b0;
        o_we      = 1'b0;
        ram_waddr = nk_reg;
        ram_raddr = scan_cell;
        g_wdata   = ng_reg;
        f_wdata   = FW'(ng_reg) + heur({1'b0, CoordW'(nk_reg[AW-1:CW])},
                    {1'b0, CoordW'(nk_reg[CW-1:0])}, tr_reg, tc_reg);
        o_wdata   = order_reg;
        p_wdata   = best_reg;
        unique case (state_reg)
            S_CHECK:
            begin
                ram_waddr = s_cell;
                g_wdata   = '0;
                f_wdata   = heur({1'b0, sr_reg}, {1'b0, sc_reg}, tr_reg, tc_reg);
                p_wdata   = s_cell;
                o_wdata   = '0;
            end
            S_NREAD:  ram_raddr = nb_cell;
            S_EXPAND: ram_raddr = best_reg;
            S_WALK:   ram_raddr = walk_reg;
            default:  ;
        endcase
        if (state_reg == S_CHECK)
        begin
            ram_we = ends_ok && !same_end;
            o_we   = ram_we;
        end
        else if (state_reg == S_NUPD && nvalid_reg)
        begin
            ram_we = !open_reg[nk_reg] || (ng_reg < g_rdata);
            o_we   = !open_reg[nk_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            straight_reg  <= CostW'(10);
            diagonal_reg  <= CostW'(14);
            rows_reg      <= DimW'(8);
            cols_reg      <= DimW'(8);
            blocked_reg   <= '0;
            open_reg      <= '0;
            closed_reg    <= '0;
            order_reg     <= '0;
            res_valid_reg <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    REG_STRAIGHT: straight_reg <= cfg.data.data;
                    REG_DIAGONAL: diagonal_reg <= cfg.data.data;
                    REG_ROWS:     rows_reg     <= cfg.data.data[DimW-1:0];
                    REG_COLS:     cols_reg     <= cfg.data.data[DimW-1:0];
                    default: ;
                endcase
            end
            // endpoint results are raised by the check, search results in S_OUT
            if (out_fire)
            begin
                res_valid_reg <= 1'b0;
            end
            else if ((state_reg == S_CHECK && !ram_we) || state_reg == S_OUT)
            begin
                res_valid_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && item_in.data.action == ACTION_LOAD
                        && 32'(item_in.data.pos_row) < MAX_ROWS
                        && 32'(item_in.data.pos_col) < MAX_COLS)
                    begin
                        blocked_reg[cell_of(item_in.data.pos_row, item_in.data.pos_col)]
                            <= item_in.data.blocked;
                    end
                end
                S_CHECK:
                begin
                    if (ram_we)
                    begin
                        open_reg   <= NCells'(1) << s_cell;
                        closed_reg <= '0;
                        order_reg  <= OrdW'(1);
                    end
                    have_best_reg <= 1'b0;
                end
                S_SCANW:
                begin
                    if (open_reg[nk_reg] && better)
                    begin
                        have_best_reg <= 1'b1;
                    end
                end
                S_EXPAND:
                begin
                    open_reg[best_reg]   <= 1'b0;
                    closed_reg[best_reg] <= 1'b1;
                    have_best_reg        <= 1'b0;
                end
                S_NUPD:
                begin
                    if (nvalid_reg && !open_reg[nk_reg])
                    begin
                        open_reg[nk_reg] <= 1'b1;
                        order_reg <= order_reg + OrdW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sr_reg  <= item_in.data.pos_row;
                sc_reg  <= item_in.data.pos_col;
                tr_reg  <= item_in.data.target_row;
                tc_reg  <= item_in.data.target_col;
                idx_reg <= '0;
            end
            S_CHECK:
            begin
                idx_reg <= '0;
                res_reg.path_row <= (ends_ok && same_end) ? sr_reg : '0;
                res_reg.path_col <= (ends_ok && same_end) ? sc_reg : '0;
                res_reg.last     <= 1'b1;
                res_reg.status   <= (ends_ok && same_end) ? STATUS_PATH : STATUS_BAD_END;
            end
            S_SCAN:
            begin
                // read issued for scan_cell; remember it for the compare
                best_reg <= have_best_reg ? best_reg : scan_cell;
                nk_reg   <= scan_cell;
            end
            S_SCANW:
            begin
                if (open_reg[nk_reg] && better)
                begin
                    best_reg   <= nk_reg;
                    best_f_reg <= f_rdata;
                    best_o_reg <= o_rdata;
                end
                idx_reg <= idx_reg + (AW+1)'(1);
            end
            S_EXPAND:
            begin
                nb_reg <= '0;
                res_reg.path_row <= '0;
                res_reg.path_col <= '0;
                res_reg.status   <= STATUS_NO_PATH;
                res_reg.last     <= 1'b1;
            end
            S_GREAD:
            begin
                best_g_reg <= g_rdata;
            end
            S_NREAD:
            begin
                nk_reg     <= nb_cell;
                ng_reg     <= ng_calc;
                nvalid_reg <= nb_in && !blocked_reg[nb_cell] && !closed_reg[nb_cell];
            end
            S_NUPD:
            begin
                nb_reg <= nb_reg + 4'd1;
                walk_reg <= t_cell;
                clen_reg <= '0;
                idx_reg  <= '0;
            end
            S_WALKW:
            begin
                clen_reg <= clen_reg + (AW+1)'(1);
                walk_reg <= p_rdata;
            end
            S_EMITW:
            begin
                res_reg.path_row <= CoordW'(c_rdata[AW-1:CW]);
                res_reg.path_col <= CoordW'(c_rdata[CW-1:0]);
                res_reg.status   <= STATUS_PATH;
                res_reg.last     <= (emit_pos == '0);
                clen_reg         <= emit_pos;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire && item_in.data.action == ACTION_SOLVE)
                    state_next = S_CHECK;
            S_CHECK:  state_next = ram_we ? S_SCAN : S_OUT;
            S_SCAN:   state_next = S_SCANW;
            S_SCANW:
                if (idx_reg == (AW+1)'(NCells - 1))
                    state_next = (open_reg[nk_reg] && better) || have_best_reg
                                 ? S_EXPAND : S_OUT;
                else
                    state_next = S_SCAN;
            S_EXPAND: state_next = S_GREAD;
            S_GREAD:  state_next = S_NREAD;
            S_NREAD:  state_next = S_NUPD;
            S_NUPD:
                if (nvalid_reg && nk_reg == t_cell)
                    state_next = S_WALK;
                else if (nb_reg == 4'd8)
                    state_next = S_SCAN;
                else
                    state_next = S_NREAD;
            S_WALK:   state_next = S_WALKW;
            S_WALKW:  state_next = (walk_reg == s_cell) ? S_EMIT : S_WALK;
            S_EMIT:   state_next = S_EMITW;
            S_EMITW:  state_next = S_OUT;
            S_OUT:
                if (!res_valid_reg || out_fire)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // path results: wait for each to drain, then emit the next
        if (state_reg == S_OUT && res_valid_reg && !res_reg.last && out_fire)
            state_next = S_EMIT;
        if (state_reg == S_OUT && res_valid_reg && !out_fire)
            state_next = S_OUT;
        if (state_reg == S_OUT && !res_valid_reg)
            state_next = S_OUT;
        if (state_reg == S_OUT && res_valid_reg && res_reg.last && out_fire)
            state_next = S_IDLE;
    end

endmodule

`default_nettype wire
